[src/tbrl_pkg.sv]
// Token bucket rate limiter: shared field widths, codes and word formats.
// No dependencies; compiled first.
`default_nettype none

package tbrl_pkg;

   localparam int FUNC_W    = 3;
   localparam int NOW_W     = 48;
   localparam int AMT_W     = 32;
   localparam int LEVEL_W   = 40;
   localparam int WSEC_W    = 40;
   localparam int WUSEC_W   = 20;
   localparam int CFG_W     = 32;
   localparam int CSR_IDX_W = 8;
   localparam int PROD_W    = 2 * CFG_W;
   localparam int MUL_STEPS = CFG_W;
   localparam int DIV_STEPS = PROD_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   localparam logic [FUNC_W-1:0] FN_DRAIN    = 3'd0;
   localparam logic [FUNC_W-1:0] FN_FORCE    = 3'd1;
   localparam logic [FUNC_W-1:0] FN_TO_LEVEL = 3'd2;
   localparam logic [FUNC_W-1:0] FN_TO_FULL  = 3'd3;
   localparam logic [FUNC_W-1:0] FN_EMPTY    = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_DEPTH = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RATE  = 8'd1;

   localparam logic [CFG_W-1:0] DEPTH_RESET  = 32'd1048576;
   localparam logic [CFG_W-1:0] RATE_RESET   = 32'd1000000;
   localparam logic [CFG_W-1:0] USEC_PER_SEC = 32'd1000000;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [NOW_W-1:0]  now_us;
      logic [AMT_W-1:0]  amount;
   } req_word_type;

   typedef struct packed {
      logic                      enough;
      logic signed [LEVEL_W-1:0] level;
      logic [WSEC_W-1:0]         wait_sec;
      logic [WUSEC_W-1:0]        wait_usec;
   } rsp_word_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] reg_idx;
      logic [CFG_W-1:0]     data;
   } csr_word_type;

endpackage

`default_nettype wire

[src/tbrl_ifs.sv]
// Token bucket rate limiter: valid/ready channel interfaces.
// Depends on tbrl_pkg for the word formats.
`default_nettype none

interface tbrl_req_if;
   import tbrl_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface tbrl_rsp_if;
   import tbrl_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface tbrl_csr_if;
   import tbrl_pkg::*;
   logic         valid;
   logic         ready;
   csr_word_type word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

`default_nettype wire

[src/token_bucket_rate_limiter_core.sv]
// Token bucket rate limiter top level: refill, drain and wait-time queries
// on a bit-serial shift-add multiplier and restoring divider.
// Depends on tbrl_pkg and the channel interfaces in tbrl_ifs.
//
//   channel  dir  word
//   req_if   in   func, now_us, amount
//   rsp_if   out  enough, level, wait_sec, wait_usec
//   csr_if   in   reg_idx, data (always ready)
//
// One item at a time. Refill: a multiply, then a divide. Wait queries
// add a divide, a multiply and another divide after the refill.
// Empty, the reserved codes and any word on a full bucket skip the
// refill; drains and forces run no wait-time divides.
// Synchronous reset: bucket full, last time zero, registers at defaults.
// A held result blocks only the final write-back; the next word is taken
// once the result register is loaded.
`default_nettype none

module token_bucket_rate_limiter_core #(
   parameter int TOKEN_BITS = 40,
   parameter int TIME_BITS  = 48
) (
   input  logic        clock,
   input  logic        reset,
   tbrl_req_if.sink    req_if,
   tbrl_rsp_if.source  rsp_if,
   tbrl_csr_if.sink    csr_if
);
   import tbrl_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_SETUP  = 9'b000000010,
      S_MUL    = 9'b000000100,
      S_DIV    = 9'b000001000,
      S_REFILL = 9'b000010000,
      S_EXEC   = 9'b000100000,
      S_QSEC   = 9'b001000000,
      S_QUSEC  = 9'b010000000,
      S_OUT    = 9'b100000000
   } state_type;

   typedef enum logic [1:0] {
      PASS_REFILL = 2'd0,
      PASS_NEED   = 2'd1,
      PASS_USEC   = 2'd2
   } pass_type;

   localparam logic signed [TOKEN_BITS-1:0] TOKEN_LOW = {1'b1, {(TOKEN_BITS-1){1'b0}}};

   state_type                     state_ff, state_in;
   pass_type                      pass_ff, pass_in;
   logic [CFG_W-1:0]              depth_ff, depth_in;
   logic [CFG_W-1:0]              rate_ff, rate_in;
   logic signed [TOKEN_BITS-1:0]  count_ff, count_in;
   logic [TIME_BITS-1:0]          last_ff, last_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_word_type                  rsp_word_ff, rsp_word_in;

   logic [FUNC_W-1:0]             func_ff, func_in;
   logic [TIME_BITS-1:0]          now_ff, now_in;
   logic [AMT_W-1:0]              amount_ff, amount_in;
   logic [TOKEN_BITS:0]           room_ff, room_in;
   logic [PROD_W-1:0]             shift_ff, shift_in;
   logic [CFG_W-1:0]              mcand_ff, mcand_in;
   logic [CFG_W-1:0]              rem_ff, rem_in;
   logic [STEP_W-1:0]             step_ff, step_in;
   logic                          enough_ff, enough_in;
   logic [WSEC_W-1:0]             wsec_ff, wsec_in;
   logic [WUSEC_W-1:0]            wusec_ff, wusec_in;

   logic [TIME_BITS-1:0]          now_ext, now_clamped;
   logic [CFG_W-1:0]              elapsed;
   logic signed [TOKEN_BITS:0]    room_calc;
   logic [CFG_W:0]                mul_sum;
   logic [CFG_W:0]                div_trial;
   logic [CFG_W+1:0]              div_diff;
   logic                          div_fit;
   logic                          add_gt_room;
   logic signed [TOKEN_BITS-1:0]  count_plus;
   logic signed [TOKEN_BITS:0]    drain_diff;
   logic                          drain_ok, drain_under;
   logic signed [TOKEN_BITS:0]    target, need_diff;
   logic                          need_pos;
   logic                          q_over;

   assign now_ext     = TIME_BITS'(req_if.word.now_us);
   assign now_clamped = (now_ext < last_ff) ? last_ff : now_ext;
   assign elapsed     = now_ff[CFG_W-1:0] - last_ff[CFG_W-1:0];
   assign room_calc   = signed'({{(TOKEN_BITS+1-CFG_W){1'b0}}, depth_ff})
                        - (TOKEN_BITS+1)'(count_ff);

   assign mul_sum   = {1'b0, shift_ff[PROD_W-1:CFG_W]}
                      + (shift_ff[0] ? {1'b0, mcand_ff} : {(CFG_W+1){1'b0}});
   assign div_trial = {rem_ff, shift_ff[PROD_W-1]};
   assign div_diff  = {1'b0, div_trial} - {2'b00, mcand_ff};
   assign div_fit   = !div_diff[CFG_W+1];

   assign add_gt_room = {1'b0, shift_ff} > (PROD_W+1)'(room_ff);
   assign count_plus  = count_ff + signed'(TOKEN_BITS'(shift_ff));

   assign drain_diff  = (TOKEN_BITS+1)'(count_ff) - signed'((TOKEN_BITS+1)'(amount_ff));
   assign drain_ok    = !drain_diff[TOKEN_BITS];
   assign drain_under = drain_diff[TOKEN_BITS] != drain_diff[TOKEN_BITS-1];

   assign target    = signed'((TOKEN_BITS+1)'((func_ff == FN_TO_LEVEL) ? amount_ff
                                                                       : depth_ff));
   assign need_diff = target - (TOKEN_BITS+1)'(count_ff);
   assign need_pos  = !need_diff[TOKEN_BITS] && (|need_diff);
   assign q_over    = |shift_ff[PROD_W-1:WSEC_W];

   assign req_if.ready = (state_ff == S_IDLE);
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.word  = rsp_word_ff;
   assign csr_if.ready = 1'b1;

   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      depth_in     = depth_ff;
      rate_in      = rate_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      func_in      = func_ff;
      now_in       = now_ff;
      amount_in    = amount_ff;
      room_in      = room_ff;
      shift_in     = shift_ff;
      mcand_in     = mcand_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      enough_in    = enough_ff;
      wsec_in      = wsec_ff;
      wusec_in     = wusec_ff;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               func_in   = req_if.word.func;
               now_in    = now_clamped;
               amount_in = req_if.word.amount;
               enough_in = 1'b0;
               wsec_in   = '0;
               wusec_in  = '0;
               state_in  = S_SETUP;
            end
         end
         S_SETUP: begin
            room_in = unsigned'(room_calc);
            if (func_ff <= FN_TO_FULL) begin
               if (room_calc == '0) begin
                  last_in  = now_ff;
                  state_in = S_EXEC;
               end else begin
                  shift_in = {{(PROD_W-CFG_W){1'b0}}, elapsed};
                  mcand_in = rate_ff;
                  step_in  = '0;
                  pass_in  = PASS_REFILL;
                  state_in = S_MUL;
               end
            end else begin
               state_in = S_EXEC;
            end
         end
         S_MUL: begin
            shift_in = {mul_sum, shift_ff[CFG_W-1:1]};
            step_in  = step_ff + 1'b1;
            if (step_ff == STEP_W'(MUL_STEPS - 1)) begin
               step_in  = '0;
               rem_in   = '0;
               mcand_in = (pass_ff == PASS_REFILL) ? USEC_PER_SEC : rate_ff;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in   = div_fit ? div_diff[CFG_W-1:0] : div_trial[CFG_W-1:0];
            shift_in = {shift_ff[PROD_W-2:0], div_fit};
            step_in  = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               step_in = '0;
               unique case (pass_ff)
                  PASS_REFILL: state_in = S_REFILL;
                  PASS_NEED:   state_in = S_QSEC;
                  PASS_USEC:   state_in = S_QUSEC;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         S_REFILL: begin
            if (|shift_ff) begin
               count_in = add_gt_room ? signed'(TOKEN_BITS'(depth_ff)) : count_plus;
               last_in  = now_ff;
            end
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_OUT;
            unique case (func_ff)
               FN_DRAIN, FN_FORCE: begin
                  enough_in = drain_ok;
                  if (drain_ok) begin
                     count_in = drain_diff[TOKEN_BITS-1:0];
                  end else if (func_ff == FN_FORCE) begin
                     count_in = drain_under ? TOKEN_LOW : drain_diff[TOKEN_BITS-1:0];
                  end
               end
               FN_TO_LEVEL, FN_TO_FULL: begin
                  if (need_pos) begin
                     if (rate_ff == '0) begin
                        wsec_in = '1;
                     end else begin
                        shift_in = PROD_W'(unsigned'(need_diff));
                        rem_in   = '0;
                        mcand_in = rate_ff;
                        step_in  = '0;
                        pass_in  = PASS_NEED;
                        state_in = S_DIV;
                     end
                  end
               end
               FN_EMPTY: begin
                  count_in = '0;
                  last_in  = now_ff;
               end
               default: begin
               end
            endcase
         end
         S_QSEC: begin
            wsec_in  = q_over ? {WSEC_W{1'b1}} : shift_ff[WSEC_W-1:0];
            mcand_in = rem_ff;
            shift_in = PROD_W'(USEC_PER_SEC);
            step_in  = '0;
            pass_in  = PASS_USEC;
            state_in = S_MUL;
         end
         S_QUSEC: begin
            wusec_in = shift_ff[WUSEC_W-1:0];
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_word_in.enough    = enough_ff;
               rsp_word_in.level     = LEVEL_W'(count_ff);
               rsp_word_in.wait_sec  = wsec_ff;
               rsp_word_in.wait_usec = wusec_ff;
               rsp_valid_in          = 1'b1;
               state_in              = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (csr_if.valid) begin
         unique case (csr_if.word.reg_idx)
            REG_DEPTH: begin
               depth_in = csr_if.word.data;
               count_in = signed'(TOKEN_BITS'(csr_if.word.data));
            end
            REG_RATE: rate_in = csr_if.word.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pass_ff      <= PASS_REFILL;
         depth_ff     <= DEPTH_RESET;
         rate_ff      <= RATE_RESET;
         count_ff     <= signed'(TOKEN_BITS'(DEPTH_RESET));
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         depth_ff     <= depth_in;
         rate_ff      <= rate_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      func_ff     <= func_in;
      now_ff      <= now_in;
      amount_ff   <= amount_in;
      room_ff     <= room_in;
      shift_ff    <= shift_in;
      mcand_ff    <= mcand_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      enough_ff   <= enough_in;
      wsec_ff     <= wsec_in;
      wusec_ff    <= wusec_in;
   end

`ifndef NO_ASSERTIONS
   a_count_le_depth: assert property (@(posedge clock) disable iff (reset)
      count_ff <= $signed({1'b0, depth_ff}))
      else $error("token count above bucket depth");

   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < mcand_ff))
      else $error("divider remainder not below divisor");

   a_time_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (last_ff >= $past(last_ff)))
      else $error("last update time moved backward");
`endif

endmodule

`default_nettype wire

[tb/tb_token_bucket_rate_limiter_core.sv]
// Testbench for token_bucket_rate_limiter_core: directed table, then random
// phases under several bucket settings, with bursty sender and stalling receiver.
// Depends on tbrl_pkg, the tbrl_ifs channel interfaces and the core itself.
`default_nettype none

module tb_token_bucket_rate_limiter_core;
   timeunit 1ns;
   timeprecision 1ps;

   import tbrl_pkg::*;

   localparam logic [FUNC_W-1:0]    FN_RSVD_A  = 3'd5;
   localparam logic [FUNC_W-1:0]    FN_RSVD_B  = 3'd6;
   localparam logic [FUNC_W-1:0]    FN_RSVD_C  = 3'd7;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 8'hFE;

   localparam int          CYCLE_LIMIT = 10_000_000;
   localparam int          HOLD_CYCLES = 3000;
   localparam logic [47:0] T_JUMP      = 48'd4294972313;
   localparam logic [47:0] T_LATE      = T_JUMP + 48'd2000000;
   localparam longint      TOKEN_LOW   = -(64'sd1 <<< (LEVEL_W - 1));

   typedef struct {
      logic [FUNC_W-1:0]  func;
      logic [NOW_W-1:0]   now_us;
      logic [AMT_W-1:0]   amount;
      int                 reps;
      bit                 fixed;
      bit                 ok;
      longint             lvl;
      logic [WSEC_W-1:0]  wsec;
      logic [WUSEC_W-1:0] wusec;
   } drill_row_type;

   // Rows marked fixed carry their result; the rest go through the predictor.
   drill_row_type drill_tab [24] = '{
      '{FN_TO_FULL,  48'd0,     32'd0,          1,   1, 0, 64'sd1048576, 40'd0, 20'd0},
      '{FN_DRAIN,    48'd0,     32'd0,          1,   1, 1, 64'sd1048576, 40'd0, 20'd0},
      '{FN_DRAIN,    48'd0,     32'd1048576,    1,   1, 1, 64'sd0, 40'd0, 20'd0},
      '{FN_DRAIN,    48'd0,     32'd1,          1,   1, 0, 64'sd0, 40'd0, 20'd0},
      '{FN_TO_LEVEL, 48'd0,     32'd1000000,    1,   1, 0, 64'sd0, 40'd1, 20'd0},
      '{FN_TO_LEVEL, 48'd0,     32'd1500000,    1,   1, 0, 64'sd0, 40'd1, 20'd500000},
      '{FN_TO_LEVEL, 48'd0,     32'd0,          1,   1, 0, 64'sd0, 40'd0, 20'd0},
      '{FN_TO_LEVEL, 48'd0,     32'hFFFF_FFFF,  1,   1, 0, 64'sd0, 40'd4294, 20'd967295},
      '{FN_FORCE,    48'd0,     32'hFFFF_FFFF,  1,   1, 0, -64'sd4294967295, 40'd0, 20'd0},
      '{FN_FORCE,    48'd0,     32'hFFFF_FFFF,  130, 0, 0, 64'sd0, 40'd0, 20'd0},
      '{FN_DRAIN,    48'd0,     32'd0,          1,   1, 0, -64'sd549755813888, 40'd0, 20'd0},
      '{FN_TO_FULL,  48'd0,     32'd0,          1,   1, 0, -64'sd549755813888,
        40'd549756, 20'd862464},
      '{FN_EMPTY,    48'd5000,  32'd77,         1,   1, 0, 64'sd0, 40'd0, 20'd0},
      '{FN_DRAIN,    48'd100,   32'd0,          1,   1, 1, 64'sd0, 40'd0, 20'd0},
      '{FN_DRAIN,    48'd5010,  32'd10,         1,   1, 1, 64'sd0, 40'd0, 20'd0},
      '{FN_TO_FULL,  48'd5010,  32'd0,          1,   1, 0, 64'sd0, 40'd1, 20'd48576},
      '{FN_FORCE,    T_JUMP,    32'd0,          1,   0, 0, 64'sd0, 40'd0, 20'd0},
      '{FN_RSVD_C,   48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 0, 64'sd0, 40'd0, 20'd0},
      '{FN_RSVD_A,   48'hAAAA_AAAA_AAAA, 32'h5555_5555, 1, 0, 0, 64'sd0, 40'd0, 20'd0},
      '{FN_RSVD_B,   48'h5555_5555_5555, 32'hAAAA_AAAA, 1, 0, 0, 64'sd0, 40'd0, 20'd0},
      '{FN_TO_LEVEL, T_LATE,    32'hFFFF_FFFF,  1,   0, 0, 64'sd0, 40'd0, 20'd0},
      '{FN_DRAIN,    T_LATE,    32'd1048577,    1,   1, 0, 64'sd1048576, 40'd0, 20'd0},
      '{FN_TO_FULL,  T_LATE,    32'd0,          1,   1, 0, 64'sd1048576, 40'd0, 20'd0},
      '{FN_EMPTY,    T_LATE,    32'd0,          1,   1, 0, 64'sd0, 40'd0, 20'd0}
   };

   logic clock;
   logic reset;

   tbrl_req_if req_if ();
   tbrl_rsp_if rsp_if ();
   tbrl_csr_if csr_if ();

   token_bucket_rate_limiter_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // bucket predictor state
   logic [CFG_W-1:0] depth_cfg;
   logic [CFG_W-1:0] rate_cfg;
   longint           tokens;
   logic [NOW_W-1:0] stamp_us;

   rsp_word_type level_q [$];
   bit           fix_valid;
   rsp_word_type fix_word;

   int          errors    = 0;
   int          checked_n = 0;
   int          sent_n    = 0;
   int          csr_n     = 0;
   int          cycles    = 0;
   int          burst_left = 0;
   int          func_seen [8];
   bit          hold_go   = 0;
   bit          hold_done = 0;
   logic [47:0] now_base;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("MISMATCH %s: got 0x%0h want 0x%0h (result %0d)", what, got, want, checked_n);
      errors++;
   endtask

   function automatic rsp_word_type bucket_step(input req_word_type w);
      logic [NOW_W-1:0] t;
      logic [63:0]      elapsed;
      logic [63:0]      add;
      logic [63:0]      need;
      logic [63:0]      quo;
      logic [63:0]      rem;
      logic [63:0]      rate64;
      longint           dep;
      longint           amt;
      longint           target;
      rsp_word_type     res;
      res     = '0;
      t       = (w.now_us < stamp_us) ? stamp_us : w.now_us;
      dep     = longint'({32'd0, depth_cfg});
      amt     = longint'({32'd0, w.amount});
      rate64  = {32'd0, rate_cfg};
      if (w.func <= FN_TO_FULL) begin
         if (tokens == dep) begin
            stamp_us = t;
         end else begin
            elapsed = {32'd0, 32'(t - stamp_us)};
            add     = (rate64 * elapsed) / 64'd1000000;
            if (add != 0) begin
               if (tokens + longint'(add) > dep)
                  tokens = (tokens > dep) ? tokens : dep;
               else
                  tokens = tokens + longint'(add);
               stamp_us = t;
            end
         end
      end
      case (w.func)
         FN_DRAIN, FN_FORCE: begin
            if (tokens >= 0 && amt <= tokens) begin
               res.enough = 1'b1;
               tokens     = tokens - amt;
            end else if (w.func == FN_FORCE) begin
               if (tokens < TOKEN_LOW + amt) tokens = TOKEN_LOW;
               else tokens = tokens - amt;
            end
         end
         FN_TO_LEVEL, FN_TO_FULL: begin
            target = (w.func == FN_TO_LEVEL) ? amt : dep;
            if (target > tokens) begin
               need = 64'(target - tokens);
               if (rate_cfg == 0) begin
                  res.wait_sec = '1;
               end else begin
                  quo = need / rate64;
                  rem = need % rate64;
                  res.wait_sec  = (quo > 64'hFF_FFFF_FFFF) ? '1 : quo[WSEC_W-1:0];
                  quo           = (rem * 64'd1000000) / rate64;
                  res.wait_usec = quo[WUSEC_W-1:0];
               end
            end
         end
         FN_EMPTY: begin
            tokens   = 0;
            stamp_us = t;
         end
         default: ;
      endcase
      res.level = tokens[LEVEL_W-1:0];
      return res;
   endfunction

   // predictor update and result check
   always @(posedge clock) begin
      rsp_word_type want;
      rsp_word_type got;
      if (reset) begin
         depth_cfg = DEPTH_RESET;
         rate_cfg  = RATE_RESET;
         tokens    = longint'({32'd0, DEPTH_RESET});
         stamp_us  = '0;
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            csr_n++;
            case (csr_if.word.reg_idx)
               REG_DEPTH: begin
                  depth_cfg = csr_if.word.data;
                  tokens    = longint'({32'd0, csr_if.word.data});
               end
               REG_RATE: rate_cfg = csr_if.word.data;
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            func_seen[req_if.word.func]++;
            want = bucket_step(req_if.word);
            level_q.push_back(fix_valid ? fix_word : want);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.word;
            if (level_q.size() == 0) begin
               report("result with nothing pending", 64'(got.level), 0);
            end else begin
               want = level_q.pop_front();
               if (got.enough !== want.enough)
                  report("enough", 64'(got.enough), 64'(want.enough));
               if (got.level !== want.level)
                  report("level", 64'(got.level), 64'(want.level));
               if (got.wait_sec !== want.wait_sec)
                  report("wait_sec", 64'(got.wait_sec), 64'(want.wait_sec));
               if (got.wait_usec !== want.wait_usec)
                  report("wait_usec", 64'(got.wait_usec), 64'(want.wait_usec));
            end
            checked_n++;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycles, level_q.size());
         $display("token_bucket_rate_limiter_core verification failed");
         $finish;
      end
   end

   // receiver: random stall segments, plus one long hold-off
   initial begin
      int seg;
      int mode;
      rsp_if.ready = 1'b0;
      forever begin
         if (hold_go && !hold_done) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1;
         end
         seg  = $urandom_range(1, 300);
         mode = $urandom_range(0, 2);
         repeat (seg) begin
            case (mode)
               0:       rsp_if.ready <= 1'b1;
               1:       rsp_if.ready <= 1'($urandom_range(0, 1));
               default: rsp_if.ready <= ($urandom_range(0, 7) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   task automatic send_word(input req_word_type w, input bit fv, input rsp_word_type fw);
      int gap;
      int r;
      if (burst_left == 0) begin
         r = $urandom_range(0, 99);
         if (r < 30)      gap = 0;
         else if (r < 75) gap = $urandom_range(1, 8);
         else if (r < 95) gap = $urandom_range(9, 60);
         else             gap = $urandom_range(61, 400);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_if.valid <= 1'b1;
      req_if.word  <= w;
      fix_valid    <= fv;
      fix_word     <= fw;
      do @(posedge clock); while (!req_if.ready);
      burst_left--;
      sent_n++;
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (level_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_if.word  <= '{reg_idx: idx, data: val};
      csr_if.valid <= 1'b1;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(input int n_items, input logic [CFG_W-1:0] dep);
      req_word_type w;
      logic [47:0]  back;
      int           r;
      for (int i = 0; i < n_items; i++) begin
         r = $urandom_range(0, 99);
         if (r < 50)      now_base += 48'($urandom_range(0, 50));
         else if (r < 80) now_base += 48'($urandom_range(0, 5000));
         else if (r < 92) now_base += 48'($urandom);
         else if (r < 96) now_base += {8'd0, 8'($urandom_range(0, 255)), 32'($urandom)};
         w.now_us = now_base;
         if (r >= 96) begin
            back     = 48'($urandom);
            w.now_us = (now_base > back) ? now_base - back : '0;
         end
         r = $urandom_range(0, 99);
         if (r < 38)      w.func = FN_DRAIN;
         else if (r < 53) w.func = FN_FORCE;
         else if (r < 68) w.func = FN_TO_LEVEL;
         else if (r < 80) w.func = FN_TO_FULL;
         else if (r < 86) w.func = FN_EMPTY;
         else begin
            case ($urandom_range(0, 2))
               0:       w.func = FN_RSVD_A;
               1:       w.func = FN_RSVD_B;
               default: w.func = FN_RSVD_C;
            endcase
            w.now_us = {16'($urandom), 32'($urandom)};
         end
         r = $urandom_range(0, 99);
         if (r < 8)       w.amount = '0;
         else if (r < 14) w.amount = '1;
         else if (r < 30) w.amount = $urandom;
         else if (w.func == FN_TO_LEVEL)
            w.amount = 32'($urandom % ({32'd0, dep} + 64'd1));
         else
            w.amount = 32'($urandom % ({32'd0, dep} / 4 + 64'd2));
         if (!hold_go && sent_n >= 200) hold_go = 1;
         send_word(w, 1'b0, '0);
      end
   endtask

   initial begin
      req_word_type     w;
      rsp_word_type     fw;
      logic [CFG_W-1:0] dep;
      logic [CFG_W-1:0] rate;
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.word  = '0;
      csr_if.valid = 1'b0;
      csr_if.word  = '0;
      fix_valid    = 1'b0;
      fix_word     = '0;
      foreach (func_seen[k]) func_seen[k] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (drill_tab[i]) begin
         for (int k = 0; k < drill_tab[i].reps; k++) begin
            w  = '{func: drill_tab[i].func, now_us: drill_tab[i].now_us,
                   amount: drill_tab[i].amount};
            fw = '{enough: drill_tab[i].ok, level: drill_tab[i].lvl[LEVEL_W-1:0],
                   wait_sec: drill_tab[i].wsec, wait_usec: drill_tab[i].wusec};
            send_word(w, drill_tab[i].fixed, fw);
         end
      end
      now_base = T_LATE;

      run_phase(260, DEPTH_RESET);

      settle();
      write_reg(REG_DEPTH, 32'd1);
      write_reg(REG_RATE, 32'hFFFF_FFFF);
      run_phase(180, 32'd1);

      settle();
      write_reg(REG_DEPTH, 32'hFFFF_FFFF);
      write_reg(REG_RATE, 32'd1);
      run_phase(180, 32'hFFFF_FFFF);

      // no refill at all; time queries saturate
      settle();
      dep = ($urandom >> $urandom_range(0, 31)) | 32'd1;
      write_reg(REG_DEPTH, dep);
      write_reg(REG_RATE, 32'd0);
      write_reg(REG_UNUSED, $urandom);
      run_phase(60, dep);

      for (int p = 0; p < 3; p++) begin
         settle();
         dep  = ($urandom >> $urandom_range(0, 31)) | 32'd1;
         rate = ($urandom >> $urandom_range(0, 31)) | 32'd1;
         write_reg(REG_DEPTH, dep);
         write_reg(REG_RATE, rate);
         run_phase(230, dep);
      end

      settle();
      write_reg(REG_DEPTH, 32'hFFFF_FFFF);
      write_reg(REG_RATE, 32'hFFFF_FFFF);
      run_phase(200, 32'hFFFF_FFFF);

      // end of time: everything after this clamps to the last stamp
      w = '{func: FN_DRAIN, now_us: 48'hFFFF_FFFF_FFFF, amount: 32'd1000};
      send_word(w, 1'b0, '0);
      w = '{func: FN_TO_FULL, now_us: 48'd12345, amount: 32'd0};
      send_word(w, 1'b0, '0);
      w = '{func: FN_EMPTY, now_us: 48'd0, amount: 32'hFFFF_FFFF};
      send_word(w, 1'b0, '0);

      settle();
      repeat (300) @(posedge clock);

      $display("%0d words: drain %0d force %0d to-level %0d to-full %0d empty %0d rsvd %0d",
               sent_n, func_seen[FN_DRAIN], func_seen[FN_FORCE], func_seen[FN_TO_LEVEL],
               func_seen[FN_TO_FULL], func_seen[FN_EMPTY],
               func_seen[FN_RSVD_A] + func_seen[FN_RSVD_B] + func_seen[FN_RSVD_C]);
      $display("%0d results checked, %0d register writes, %0d mismatches, %0d cycles",
               checked_n, csr_n, errors, cycles);
      if (errors == 0)
         $display("token_bucket_rate_limiter_core verification clean");
      else
         $display("token_bucket_rate_limiter_core verification failed");
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
src/tbrl_pkg.sv
src/tbrl_ifs.sv
src/token_bucket_rate_limiter_core.sv
tb/tb_token_bucket_rate_limiter_core.sv
